>>> sv/psrb_pkg.sv
`default_nettype none

package psrb_pkg;

    localparam int SEQ_W = 32;
    localparam int KEY_W = SEQ_W + 1;
    localparam int TAG_W_PORT = 16;
    localparam int VER_W = 8;
    localparam int EV_W = 2;

    localparam logic [VER_W-1:0] VERSION_RESET = 8'd15;

    localparam logic [EV_W-1:0] EV_DELIVER = 2'd0;
    localparam logic [EV_W-1:0] EV_LOST    = 2'd1;
    localparam logic [EV_W-1:0] EV_CLEARED = 2'd2;

    // Broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic                  wr_en;
        logic [SEQ_W-1:0]      wr_seq;
        logic [TAG_W_PORT-1:0] wr_tag;
        logic                  free_hit;
        logic                  clr_all;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/psrb_cell.sv
`default_nettype none

module psrb_cell
    import psrb_pkg::*;
#(
    parameter int TAG_W = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic             take_in,
    output logic                  take_out,
    output logic                  valid,
    output logic                  hit,
    output logic [TAG_W-1:0]      hit_tag
);

    logic             valid_reg;
    logic             valid_next;
    logic             match_reg;
    logic             match_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             load;

    // Grant passes on only past occupied cells: the first free cell takes the write.
    assign take_out = take_in & valid_reg;
    assign load     = ctrl.wr_en & take_in & ~valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clr_all)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.free_hit && match_reg)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            valid_next = 1'b1;
        end
        match_next = valid_reg & ({1'b0, seq_reg} == ctrl.key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_reg <= ctrl.wr_seq;
            tag_reg <= ctrl.wr_tag[TAG_W-1:0];
        end
    end

    assign valid   = valid_reg;
    assign hit     = match_reg;
    assign hit_tag = match_reg ? tag_reg : '0;

endmodule

`default_nettype wire

>>> sv/packet_sequence_reorder_buffer.sv
// Flow: a header is accepted only in idle, once the previous header is finished. Each
//   packet drained from the slots passes S_DRAIN_KEY and then S_DRAIN_R, as set by the
//   registered compare in every slot cell; a lost number first passes the slot lookup
//   (S_LOOKUP, S_LOOKUP_R). Output stalls can hold the sequencer.
// Reset (rst_n, asynchronous, active low): all slots empty, last delivered number 0,
//   expected version 15, output empty.
`default_nettype none

module packet_sequence_reorder_buffer
    import psrb_pkg::*;
#(
    parameter int SLOTS    = 8,
    parameter int TAG_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data,     // expected_version
    // header input
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [55:0]  s_tdata,      // version[7:0], seq_number[39:8], packet_tag[55:40]
    // result output
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,      // out_tag[15:0], out_seq[47:16]
    output logic [1:0]        m_tuser,      // event_res[1:0]
    output logic              m_tlast       // last
);

    // Stored tag width: the port carries 16 bits, so anything above is always zero.
    localparam int TW = (TAG_BITS < TAG_W_PORT) ? TAG_BITS : TAG_W_PORT;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_LOOKUP    = 3'd2;
    localparam logic [2:0] S_LOOKUP_R  = 3'd3;
    localparam logic [2:0] S_DRAIN_KEY = 3'd4;
    localparam logic [2:0] S_DRAIN_R   = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [VER_W-1:0]      ver_cfg_reg;
    // Holds last_delivered + 1, 33 bits wide so the top of the number space matches nothing.
    logic [KEY_W-1:0]      next_reg, next_next;
    logic                  restart_reg, restart_next;

    // Accepted header
    logic [VER_W-1:0]      item_ver_reg;
    logic [SEQ_W-1:0]      item_seq_reg;
    logic [TAG_W_PORT-1:0] item_tag_reg;
    logic [TAG_W_PORT-1:0] item_tag_m;

    // Pending result: held back one step until it is known whether it is the last one
    logic                  pend_valid_reg, pend_valid_next;
    logic [EV_W-1:0]       pend_ev_reg, pend_ev_next;
    logic [TAG_W_PORT-1:0] pend_tag_reg, pend_tag_next;
    logic [SEQ_W-1:0]      pend_seq_reg, pend_seq_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [EV_W-1:0]       out_ev_reg, out_ev_next;
    logic [TAG_W_PORT-1:0] out_tag_reg, out_tag_next;
    logic [SEQ_W-1:0]      out_seq_reg, out_seq_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  go;
    logic                  do_emit;
    logic                  do_fin;
    logic [EV_W-1:0]       emit_ev;
    logic [TAG_W_PORT-1:0] emit_tag;
    logic [SEQ_W-1:0]      emit_seq;

    // Slot chain
    cell_ctrl_t            ctrl;
    logic [SLOTS:0]        take;
    logic [SLOTS-1:0]      valid_vec;
    logic [SLOTS-1:0]      hit_vec;
    logic [TW-1:0]         hit_tag [SLOTS];
    logic [TW-1:0]         hit_tag_or;
    logic [TAG_W_PORT-1:0] hit_tag_ext;
    logic                  hit_any;
    logic                  any_valid;
    logic                  any_free;
    logic                  key_item;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_cfg_reg <= VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ver_cfg_reg <= cfg_data;
        end
    end

    // Latch the header on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_ver_reg <= s_tdata[7:0];
            item_seq_reg <= s_tdata[39:8];
            item_tag_reg <= s_tdata[55:40];
        end
    end

    always_comb
    begin
        item_tag_m         = '0;
        item_tag_m[TW-1:0] = item_tag_reg[TW-1:0];
    end

    // ---------------------------------------------------------------
    // Slot cells: the free-slot grant ripples from cell 0 upward; each
    // cell compares the broadcast key and registers its own match.
    // ---------------------------------------------------------------
    assign take[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            psrb_cell #(
                .TAG_W (TW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .take_in  (take[gi]),
                .take_out (take[gi+1]),
                .valid    (valid_vec[gi]),
                .hit      (hit_vec[gi]),
                .hit_tag  (hit_tag[gi])
            );
        end
    endgenerate

    // Stored numbers are unique, so at most one cell matches and an OR picks its tag.
    always_comb
    begin
        hit_tag_or = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_tag_or = hit_tag_or | hit_tag[i];
        end
        hit_tag_ext         = '0;
        hit_tag_ext[TW-1:0] = hit_tag_or;
    end

    assign hit_any   = |hit_vec;
    assign any_valid = |valid_vec;
    assign any_free  = ~take[SLOTS];

    assign out_free = ~out_valid_reg | m_tready;
    // A new result may replace the pending one only if that one can move to the output.
    assign go       = ~pend_valid_reg | out_free;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        next_next     = next_reg;
        restart_next  = restart_reg;
        do_emit       = 1'b0;
        do_fin        = 1'b0;
        emit_ev       = EV_DELIVER;
        emit_tag      = '0;
        emit_seq      = '0;
        key_item      = 1'b0;

        ctrl          = '0;
        ctrl.wr_seq   = item_seq_reg;
        ctrl.wr_tag   = item_tag_m;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (item_ver_reg != ver_cfg_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (item_seq_reg == 32'd1)
                begin
                    // Restart: deliver, then drain and clear what is left
                    do_emit      = 1'b1;
                    emit_ev      = EV_DELIVER;
                    emit_tag     = item_tag_m;
                    emit_seq     = item_seq_reg;
                    next_next    = 33'd2;
                    restart_next = 1'b1;
                    state_next   = S_DRAIN_KEY;
                end
                else if ({1'b0, item_seq_reg} == next_reg)
                begin
                    do_emit      = 1'b1;
                    emit_ev      = EV_DELIVER;
                    emit_tag     = item_tag_m;
                    emit_seq     = item_seq_reg;
                    next_next    = next_reg + 33'd1;
                    restart_next = 1'b0;
                    state_next   = S_DRAIN_KEY;
                end
                else if ({1'b0, item_seq_reg} > next_reg)
                begin
                    state_next = S_LOOKUP;
                end
                else
                begin
                    // Stale or repeated number
                    state_next = S_IDLE;
                end
            end
            S_LOOKUP:
            begin
                key_item   = 1'b1;
                state_next = S_LOOKUP_R;
            end
            S_LOOKUP_R:
            begin
                key_item = 1'b1;
                if (hit_any)
                begin
                    // Already parked: drop the duplicate
                    state_next = S_IDLE;
                end
                else if (any_free)
                begin
                    ctrl.wr_en = 1'b1;
                    state_next = S_IDLE;
                end
                else if (go)
                begin
                    // No room: give up on the missing number and drop this packet
                    do_emit      = 1'b1;
                    emit_ev      = EV_LOST;
                    emit_seq     = next_reg[SEQ_W-1:0];
                    next_next    = next_reg + 33'd1;
                    restart_next = 1'b0;
                    state_next   = S_DRAIN_KEY;
                end
            end
            S_DRAIN_KEY:
            begin
                state_next = S_DRAIN_R;
            end
            S_DRAIN_R:
            begin
                if (hit_any)
                begin
                    if (go)
                    begin
                        do_emit       = 1'b1;
                        emit_ev       = EV_DELIVER;
                        emit_tag      = hit_tag_ext;
                        emit_seq      = next_reg[SEQ_W-1:0];
                        ctrl.free_hit = 1'b1;
                        next_next     = next_reg + 33'd1;
                        state_next    = S_DRAIN_KEY;
                    end
                end
                else if (restart_reg && any_valid)
                begin
                    if (go)
                    begin
                        do_emit      = 1'b1;
                        emit_ev      = EV_CLEARED;
                        ctrl.clr_all = 1'b1;
                        state_next   = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    do_fin     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ctrl.key = key_item ? {1'b0, item_seq_reg} : next_reg;
    end

    // Move results: pending -> output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_tag_next   = pend_tag_reg;
        pend_seq_next   = pend_seq_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_ev_next     = out_ev_reg;
        out_tag_next    = out_tag_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;

        if (do_emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_ev_next    = pend_ev_reg;
                out_tag_next   = pend_tag_reg;
                out_seq_next   = pend_seq_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_ev_next    = emit_ev;
            pend_tag_next   = emit_tag;
            pend_seq_next   = emit_seq;
        end
        else if (do_fin && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_ev_next     = pend_ev_reg;
            out_tag_next    = pend_tag_reg;
            out_seq_next    = pend_seq_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_reg       <= 33'd1;
            restart_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_reg       <= next_next;
            restart_reg    <= restart_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ev_reg  <= pend_ev_next;
        pend_tag_reg <= pend_tag_next;
        pend_seq_reg <= pend_seq_next;
        out_ev_reg   <= out_ev_next;
        out_tag_reg  <= out_tag_next;
        out_seq_reg  <= out_seq_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_seq_reg, out_tag_reg};
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // A finished header leaves nothing pending behind it
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left over in idle");

    // Every header that reaches the end has produced at least one result
    a_finish_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH |-> pend_valid_reg)
        else $error("finish without a pending result");

    // Parked numbers are unique, so the key never matches two cells
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one slot matches the key");

    // The expected number never wraps to zero
    a_next_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_reg != '0)
        else $error("expected number wrapped");
`endif

endmodule

`default_nettype wire
